@@ rtl/core/ptas_pkg.sv @@
// Shared types and constants of the periodic toggle arm scheduler.
`timescale 1ns / 1ps
`default_nettype none
package ptas_pkg;

	localparam int unsigned TimeW = 64;

	localparam logic [1:0] OP_ARM    = 2'd0;
	localparam logic [1:0] OP_FOLD   = 2'd1;
	localparam logic [1:0] OP_STOP   = 2'd2;
	localparam logic [1:0] OP_INVERT = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic [1:0] REG_AUTO_START = 2'd0;
	localparam logic [1:0] REG_ARM_MARGIN = 2'd1;
	localparam logic [1:0] REG_EDGE_DELAY = 2'd2;

	localparam logic [TimeW-1:0] TIME_LIMIT = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [7:0] EDGE_DELAY_RESET = 8'd2;

	localparam int unsigned InDataW  = 328;
	localparam int unsigned OutDataW = 136;

	typedef struct packed {
		logic load;
		logic flip;
		logic fold_start;
		logic fold_apply;
		logic prep;
		logic level_adj;
		logic div1_start;
		logic div2_start;
		logic push;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       arm_invalid;
		logic       fold_go;
		logic       push_needed;
		logic       div_busy;
		logic       out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/periodic_toggle_arm_scheduler_top.sv @@
// Usage notes:
// One input word on the s_ group carries an operation (arm, fold, stop or invert)
// with the live compare, the current time and the arm parameters. Every word gives
// exactly one result word on the m_ group: status, the write flag, the compare and
// interval to program, and the tracked level.
// The block works on one word at a time; s_tready is high only while it is idle.
// An operation without a fold and a rejected arm go straight to the result; an arm
// that neither folds nor pushes also passes the prep, level and push steps; a fold
// runs the divider once, and an arm that pushes its first edge forward runs it
// twice more. The time taken is set by the shared 64-bit divider,
// which retires one quotient bit per cycle and runs up to three times per arm.
// The result sits in an output register; the next word is accepted while it waits,
// and a stalled m_tready only holds the finished operation before its result is
// written. Configuration writes on cfg_* take effect at once and belong between
// operations. Reset clears the level, checkpoint and interval to idle, and sets
// the registers to auto start 0, arm margin 0 and edge delay 2.
`timescale 1ns / 1ps
`default_nettype none
module periodic_toggle_arm_scheduler_top import ptas_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// op[1:0], live_compare[65:2], now_time[129:66], high_time[193:130],
	// low_time[257:194], first_edge_time[321:258], zeros above
	input  wire logic [InDataW-1:0]  s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// status[1:0], write_compare[2], compare_value[66:3], interval_value[130:67],
	// level_high[131], zeros above
	output logic [OutDataW-1:0]      m_tdata,
	input  wire logic                cfg_wr_en,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	ptas_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ptas_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (s_tdata),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

endmodule
`default_nettype wire

@@ rtl/core/ptas_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ptas_div import ptas_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [TimeW-1:0] dividend,
	input  wire logic [TimeW-1:0] divisor,
	output logic                  busy,
	output logic [TimeW-1:0]      quotient,
	output logic [TimeW-1:0]      remainder
);

	localparam int unsigned CntW = $clog2(TimeW + 1);

	logic [TimeW-1:0] rem_q, quo_q, dvs_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic [TimeW:0]   shifted, diff;

	assign shifted = {rem_q, quo_q[TimeW-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(TimeW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[TimeW]) begin
				rem_q <= diff[TimeW-1:0];
				quo_q <= {quo_q[TimeW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[TimeW-1:0];
				quo_q <= {quo_q[TimeW-2:0], 1'b0};
			end
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

@@ rtl/core/ptas_dp.sv @@
// Datapath: operand, state, configuration and result registers with the shared divider.
`timescale 1ns / 1ps
`default_nettype none
module ptas_dp import ptas_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctrl_cmd_t           cmd,
	output dp_stat_t                 stat,
	input  wire logic [InDataW-1:0]  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [OutDataW-1:0]      out_data,
	input  wire logic                cfg_wr_en,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);

	logic [1:0]       op_q;
	logic [TimeW-1:0] live_q, now_q, hi_q, lo_q, req_q;
	logic [31:0]      auto_q, margin_q;
	logic [7:0]       delay_q;
	logic             level_q;
	logic [TimeW-1:0] cp_q, ai_q;
	logic [TimeW-1:0] first_q, deadline_q, period_q, q1_q, dr_q;
	logic             ovf_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic             wr_q, lvl_out_q;
	logic [TimeW-1:0] cmp_q, int_q;

	logic             div_start, div_busy;
	logic [TimeW-1:0] div_a, div_b, div_quo, div_rem;
	logic             arm_invalid;
	logic [TimeW-1:0] f0, inv_sum;

	assign arm_invalid = (hi_q == '0) || (lo_q == '0) || (hi_q > TIME_LIMIT) ||
		(lo_q > TIME_LIMIT);

	assign div_start = cmd.fold_start | cmd.div1_start | cmd.div2_start;
	always_comb begin
		div_a = ~first_q;
		div_b = period_q;
		if (cmd.fold_start) begin
			div_a = live_q - cp_q;
			div_b = ai_q;
		end else if (cmd.div1_start) begin
			div_a = deadline_q - first_q;
		end
	end

	ptas_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign f0      = (req_q != '0) ? req_q : now_q + TimeW'(auto_q);
	assign inv_sum = live_q + ai_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_q   <= '0;
			margin_q <= '0;
			delay_q  <= EDGE_DELAY_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_AUTO_START: auto_q   <= cfg_data;
				REG_ARM_MARGIN: margin_q <= cfg_data;
				REG_EDGE_DELAY: delay_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= 1'b0;
			cp_q        <= '0;
			ai_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.flip) begin
				level_q <= ~level_q;
			end
			if (cmd.fold_apply) begin
				level_q <= level_q ^ div_quo[0];
				cp_q    <= live_q;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				case (op_q)
					OP_ARM: begin
						if (!arm_invalid) begin
							ai_q <= ovf_q ? '0 : (level_q ? lo_q : hi_q);
							cp_q <= ovf_q ? '0 : first_q;
						end
					end
					OP_STOP: begin
						ai_q <= '0;
						cp_q <= '0;
					end
					OP_INVERT: begin
						if (ai_q != '0 && live_q <= ~ai_q) begin
							cp_q <= inv_sum;
						end
					end
					default: ;
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_data[1:0];
			live_q <= in_data[65:2];
			now_q  <= in_data[129:66];
			hi_q   <= in_data[193:130];
			lo_q   <= in_data[257:194];
			req_q  <= in_data[321:258];
		end
		if (cmd.prep) begin
			first_q    <= (f0 > TimeW'(delay_q)) ? f0 - TimeW'(delay_q) : f0;
			deadline_q <= now_q + TimeW'(margin_q);
			period_q   <= hi_q + lo_q;
			ovf_q      <= 1'b0;
		end
		if (cmd.level_adj && level_q) begin
			first_q <= (first_q > lo_q) ? first_q - lo_q : first_q + hi_q;
		end
		if (cmd.div2_start) begin
			q1_q <= div_quo;
			dr_q <= deadline_q - div_rem;
		end
		if (cmd.push) begin
			// Whole periods past the deadline: deadline - remainder + period.
			ovf_q   <= (q1_q >= div_quo);
			first_q <= dr_q + period_q;
		end
		if (cmd.finish) begin
			lvl_out_q <= level_q;
			status_q  <= ST_OK;
			wr_q      <= 1'b0;
			cmp_q     <= '0;
			int_q     <= ai_q;
			case (op_q)
				OP_ARM: begin
					if (arm_invalid) begin
						status_q <= ST_INVALID;
					end else if (ovf_q) begin
						status_q <= ST_OVERFLOW;
						wr_q     <= 1'b1;
						int_q    <= '0;
					end else begin
						wr_q  <= 1'b1;
						cmp_q <= first_q;
						int_q <= level_q ? lo_q : hi_q;
					end
				end
				OP_STOP: begin
					wr_q  <= 1'b1;
					int_q <= '0;
				end
				OP_INVERT: begin
					if (ai_q != '0 && live_q <= ~ai_q) begin
						wr_q  <= 1'b1;
						cmp_q <= inv_sum;
					end
				end
				default: ;
			endcase
		end
	end

	assign stat.op          = op_q;
	assign stat.arm_invalid = arm_invalid;
	assign stat.fold_go     = (ai_q != '0) && (live_q >= cp_q);
	assign stat.push_needed = first_q < deadline_q;
	assign stat.div_busy    = div_busy;
	assign stat.out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = {4'b0, lvl_out_q, int_q, cmp_q, wr_q, status_q};

endmodule
`default_nettype wire

@@ rtl/core/ptas_ctrl.sv @@
// Controller state machine that sequences one operation through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module ptas_ctrl import ptas_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire dp_stat_t stat,
	output ctrl_cmd_t     cmd
);

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_CHECK     = 9'b000000010,
		S_FOLD_WAIT = 9'b000000100,
		S_PREP      = 9'b000001000,
		S_LEVEL     = 9'b000010000,
		S_PUSH      = 9'b000100000,
		S_DIV1_WAIT = 9'b001000000,
		S_DIV2_WAIT = 9'b010000000,
		S_FINISH    = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.flip = (stat.op == OP_INVERT);
				if (stat.op == OP_ARM && stat.arm_invalid) begin
					state_d = S_FINISH;
				end else if (stat.fold_go) begin
					cmd.fold_start = 1'b1;
					state_d        = S_FOLD_WAIT;
				end else begin
					state_d = (stat.op == OP_ARM) ? S_PREP : S_FINISH;
				end
			end
			S_FOLD_WAIT: begin
				if (!stat.div_busy) begin
					cmd.fold_apply = 1'b1;
					state_d        = (stat.op == OP_ARM) ? S_PREP : S_FINISH;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_LEVEL;
			end
			S_LEVEL: begin
				cmd.level_adj = 1'b1;
				state_d       = S_PUSH;
			end
			S_PUSH: begin
				if (stat.push_needed) begin
					cmd.div1_start = 1'b1;
					state_d        = S_DIV1_WAIT;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_DIV1_WAIT: begin
				if (!stat.div_busy) begin
					cmd.div2_start = 1'b1;
					state_d        = S_DIV2_WAIT;
				end
			end
			S_DIV2_WAIT: begin
				if (!stat.div_busy) begin
					cmd.push = 1'b1;
					state_d  = S_FINISH;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule
`default_nettype wire

@@ rtl/core/ptas_checker.sv @@
// Port-level checks on the scheduler's result words, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ptas_checker import ptas_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [OutDataW-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result word dropped");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3) else $error("bad status code");

	a_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[66:3] == '0)
		else $error("compare without write");

	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == ST_OVERFLOW |-> m_tdata[2] && m_tdata[130:67] == '0)
		else $error("overflow must clear the engine");

	a_inv: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == ST_INVALID |-> !m_tdata[2])
		else $error("invalid arm must not write");

endmodule

bind periodic_toggle_arm_scheduler_top ptas_checker u_ptas_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire
